// ===== rtl/ppd_pkg.sv =====
package ppd_pkg;

    localparam logic [3:0] PKT_PIX_A = 4'hA;
    localparam logic [3:0] PKT_PIX_B = 4'hB;
    localparam logic [3:0] PKT_TRIG  = 4'h5;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    localparam int COARSE_W = 16;
    localparam int RAW_W    = 30;
    localparam int WRAP_W   = 34;

    typedef struct packed {
        logic                has_result;
        logic                kind;
        logic [7:0]          col_x;
        logic [7:0]          row_y;
        logic [3:0]          fine_toa;
        logic [9:0]          over_threshold;
        logic [13:0]         arrival;
        logic [COARSE_W-1:0] coarse;
        logic [RAW_W-1:0]    raw;
        logic [14:0]         internal_trigger;
        logic [14:0]         external_trigger;
    } dec_t;

    typedef struct packed {
        logic              wrapped;
        logic [WRAP_W-1:0] count;
        logic [WRAP_W-1:0] count_next;
    } wrap_t;

endpackage

// ===== rtl/pixel_packet_decoder_time_unfold.sv =====
// The input word is decoded from the input register; its result is loaded
// into the result register when the word advances, which a held result stalls.
// Throughput: one word per cycle unless a held result stalls; decode, wrap
// compare and increment sit in one stage between input and result registers.
// Words of unknown type are consumed and give no result.
// Reset (aresetn low, synchronous) empties both registers and clears the
// last coarse counter and the wrap count.
module pixel_packet_decoder_time_unfold
    import ppd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_packet,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_col_x,
    output logic [7:0]  m_row_y,
    output logic [3:0]  m_fine_toa,
    output logic [9:0]  m_over_threshold,
    output logic [13:0] m_arrival,
    output logic [63:0] m_stamp,
    output logic [14:0] m_internal_trigger,
    output logic [14:0] m_external_trigger,
    output logic        m_unfolded
);

    logic        in_valid_reg, in_valid_next;
    logic [63:0] packet_reg;
    logic        out_valid_reg, out_valid_next;
    logic        advance;
    logic        load_result;
    dec_t        dec;
    wrap_t       wrap;

    logic        kind_reg;
    logic [7:0]  col_x_reg;
    logic [7:0]  row_y_reg;
    logic [3:0]  fine_toa_reg;
    logic [9:0]  over_threshold_reg;
    logic [13:0] arrival_reg;
    logic [63:0] stamp_reg;
    logic [14:0] internal_trigger_reg;
    logic [14:0] external_trigger_reg;
    logic        unfolded_reg;

    ppd_decode u_decode (
        .packet (packet_reg),
        .dec    (dec)
    );

    ppd_unfold u_unfold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .update  (load_result),
        .coarse  (dec.coarse),
        .wrap    (wrap)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || m_ready);
    assign load_result = advance && dec.has_result;
    assign s_ready     = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = dec.has_result;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            packet_reg <= s_packet;
        end
        if (load_result) begin
            kind_reg             <= dec.kind;
            col_x_reg            <= dec.col_x;
            row_y_reg            <= dec.row_y;
            fine_toa_reg         <= dec.fine_toa;
            over_threshold_reg   <= dec.over_threshold;
            arrival_reg          <= dec.arrival;
            stamp_reg            <= {wrap.count_next, dec.raw};
            internal_trigger_reg <= dec.internal_trigger;
            external_trigger_reg <= dec.external_trigger;
            unfolded_reg         <= wrap.wrapped;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_kind             = kind_reg;
    assign m_col_x            = col_x_reg;
    assign m_row_y            = row_y_reg;
    assign m_fine_toa         = fine_toa_reg;
    assign m_over_threshold   = over_threshold_reg;
    assign m_arrival          = arrival_reg;
    assign m_stamp            = stamp_reg;
    assign m_internal_trigger = internal_trigger_reg;
    assign m_external_trigger = external_trigger_reg;
    assign m_unfolded         = unfolded_reg;

    // held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("result register overwritten while stalled");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_result |=> m_valid)
        else $error("loaded result not presented");

    // without a wrap the offset is the count held before the word
    a_offset_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_result && !wrap.wrapped) |=>
            (m_stamp[63:30] == $past(wrap.count) && !m_unfolded))
        else $error("wrap offset changed without a wrap");

    a_offset_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_result && wrap.wrapped) |=>
            (m_stamp[63:30] == $past(wrap.count) + WRAP_W'(1) && m_unfolded))
        else $error("wrap offset did not advance by one");

endmodule

// ===== rtl/ppd_decode.sv =====
module ppd_decode
    import ppd_pkg::*;
(
    input  logic [63:0] packet,
    output dec_t        dec
);

    always_comb begin
        dec = '0;
        unique case (packet[63:60]) inside
            PKT_PIX_A, PKT_PIX_B: begin
                dec.has_result     = 1'b1;
                dec.kind           = KIND_PIXEL;
                dec.col_x          = {packet[59:53], packet[46]};
                dec.row_y          = {packet[52:47], packet[45:44]};
                dec.fine_toa       = packet[19:16];
                dec.over_threshold = packet[29:20];
                dec.arrival        = packet[43:30];
                dec.coarse         = packet[15:0];
                dec.raw            = {packet[15:0], packet[43:30]};
            end
            PKT_TRIG: begin
                dec.has_result       = 1'b1;
                dec.kind             = KIND_TRIGGER;
                dec.coarse           = packet[29:14];
                dec.raw              = packet[29:0];
                dec.internal_trigger = packet[59:45];
                dec.external_trigger = packet[44:30];
            end
            default: begin
                dec = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ppd_unfold.sv =====
module ppd_unfold
    import ppd_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                update,
    input  logic [COARSE_W-1:0] coarse,
    output wrap_t               wrap
);

    logic [COARSE_W-1:0] last_coarse_reg;
    logic [WRAP_W-1:0]   wrap_count_reg;

    always_comb begin
        wrap.wrapped    = coarse < last_coarse_reg;
        wrap.count      = wrap_count_reg;
        wrap.count_next = wrap.wrapped ? wrap_count_reg + WRAP_W'(1) : wrap_count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_coarse_reg <= '0;
            wrap_count_reg  <= '0;
        end else if (update) begin
            last_coarse_reg <= coarse;
            wrap_count_reg  <= wrap.count_next;
        end
    end

endmodule

// ===== tb/tb_pixel_packet_decoder_time_unfold.sv =====
module tb_pixel_packet_decoder_time_unfold;
    import ppd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1820;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 6;

    typedef struct packed {
        logic        kind;
        logic [7:0]  col_x;
        logic [7:0]  row_y;
        logic [3:0]  fine_toa;
        logic [9:0]  over_threshold;
        logic [13:0] arrival;
        logic [63:0] stamp;
        logic [14:0] internal_trigger;
        logic [14:0] external_trigger;
        logic        unfolded;
    } decoded_t;

    typedef struct {
        logic [63:0] packet;
        int unsigned send_idle;
        int unsigned recv_stall;
    } feed_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_packet = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_col_x;
    logic [7:0]  m_row_y;
    logic [3:0]  m_fine_toa;
    logic [9:0]  m_over_threshold;
    logic [13:0] m_arrival;
    logic [63:0] m_stamp;
    logic [14:0] m_internal_trigger;
    logic [14:0] m_external_trigger;
    logic        m_unfolded;

    pixel_packet_decoder_time_unfold dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_packet           (s_packet),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_kind             (m_kind),
        .m_col_x            (m_col_x),
        .m_row_y            (m_row_y),
        .m_fine_toa         (m_fine_toa),
        .m_over_threshold   (m_over_threshold),
        .m_arrival          (m_arrival),
        .m_stamp            (m_stamp),
        .m_internal_trigger (m_internal_trigger),
        .m_external_trigger (m_external_trigger),
        .m_unfolded         (m_unfolded)
    );

    always #2 aclk = ~aclk;

    feed_t    packet_fifo[$];
    decoded_t pending_results[$];
    feed_t    offered;

    logic [15:0] seen_coarse = '0;
    logic [33:0] wrap_total = '0;

    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 0;
    bit          word_taken = 0;
    int          words_queued = 0;
    int          words_in = 0;
    int          results_out = 0;
    int          pixel_seen = 0;
    int          trigger_seen = 0;
    int          wraps_seen = 0;
    int          mismatches = 0;
    int          quiet_cycles = 0;

    // decode one word against the tracked coarse counter and wrap total
    function automatic bit decode_word(input logic [63:0] p, output decoded_t d);
        logic [15:0] coarse;
        logic [29:0] raw;
        logic        wrapped;
        d = '0;
        if (p[63:60] == PKT_PIX_A || p[63:60] == PKT_PIX_B) begin
            d.kind = KIND_PIXEL;
            d.col_x = {p[59:53], p[46]};
            d.row_y = {p[52:47], p[45:44]};
            d.fine_toa = p[19:16];
            d.over_threshold = p[29:20];
            d.arrival = p[43:30];
            coarse = p[15:0];
            raw = {coarse, p[43:30]};
        end else if (p[63:60] == PKT_TRIG) begin
            d.kind = KIND_TRIGGER;
            d.internal_trigger = p[59:45];
            d.external_trigger = p[44:30];
            raw = p[29:0];
            coarse = raw[29:14];
        end else begin
            return 0;
        end
        wrapped = (coarse < seen_coarse);
        if (wrapped) begin
            wrap_total = wrap_total + 34'd1;
        end
        seen_coarse = coarse;
        d.stamp = 64'(raw) + {wrap_total, 30'd0};
        d.unfolded = wrapped;
        return 1;
    endfunction

    function automatic string show(input decoded_t d);
        return {$sformatf("kind=%0d col=%0d row=%0d ftoa=%0d tot=%0d toa=%0d ",
                          d.kind, d.col_x, d.row_y, d.fine_toa, d.over_threshold, d.arrival),
                $sformatf("stamp=%h int=%0d ext=%0d unf=%0d",
                          d.stamp, d.internal_trigger, d.external_trigger, d.unfolded)};
    endfunction

    function automatic string field_diff(input decoded_t g, input decoded_t w);
        string s;
        s = "";
        if (g.kind !== w.kind) s = {s, " kind"};
        if (g.col_x !== w.col_x) s = {s, " col_x"};
        if (g.row_y !== w.row_y) s = {s, " row_y"};
        if (g.fine_toa !== w.fine_toa) s = {s, " fine_toa"};
        if (g.over_threshold !== w.over_threshold) s = {s, " over_threshold"};
        if (g.arrival !== w.arrival) s = {s, " arrival"};
        if (g.stamp !== w.stamp) s = {s, " stamp"};
        if (g.internal_trigger !== w.internal_trigger) s = {s, " internal_trigger"};
        if (g.external_trigger !== w.external_trigger) s = {s, " external_trigger"};
        if (g.unfolded !== w.unfolded) s = {s, " unfolded"};
        return s;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic add_word(input logic [63:0] p, input int unsigned idle,
                            input int unsigned stall);
        feed_t f;
        f.packet = p;
        f.send_idle = idle;
        f.recv_stall = stall;
        packet_fifo.insert(packet_fifo.size(), f);
        words_queued++;
    endtask

    function automatic logic [63:0] pixel_word(input logic [15:0] coarse);
        logic [63:0] p;
        p = {$urandom, $urandom};
        p[63:60] = $urandom_range(1) ? PKT_PIX_A : PKT_PIX_B;
        p[15:0] = coarse;
        return p;
    endfunction

    function automatic logic [63:0] trigger_word(input logic [15:0] coarse);
        logic [63:0] p;
        p = {$urandom, $urandom};
        p[63:60] = PKT_TRIG;
        p[29:14] = coarse;
        return p;
    endfunction

    function automatic logic [63:0] other_word();
        logic [63:0] p;
        p = {$urandom, $urandom};
        while (p[63:60] == PKT_PIX_A || p[63:60] == PKT_PIX_B || p[63:60] == PKT_TRIG) begin
            p[63:60] = 4'($urandom_range(15));
        end
        return p;
    endfunction

    function automatic logic [15:0] next_coarse(input logic [15:0] c);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65) return c + 16'($urandom_range(200));
        if (r < 75) return c;
        if (r < 85) return c - 16'($urandom_range(1, 50));
        return 16'($urandom);
    endfunction

    // stimulus
    initial begin
        logic [15:0]  coarse;
        logic [63:0]  p;
        int           sent;
        int           ph;
        int unsigned  r;
        int unsigned  idle_tab[4];
        int unsigned  stall_tab[4];

        idle_tab  = '{0, 46, 0, 13};
        stall_tab = '{0, 0, 46, 13};

        add_word(64'h0, 0, 0);
        add_word(64'hAFFF_FFFF_FFFF_FFFF, 0, 0);
        add_word(64'hB000_0000_0000_0000, 0, 0);
        add_word(64'hB000_0000_0000_0000, 0, 0);
        add_word(64'h5FFF_FFFF_FFFF_FFFF, 0, 0);
        add_word(64'h5000_0000_0000_0000, 0, 0);
        add_word(64'h5000_0000_0000_0000, 0, 0);
        add_word(64'hA555_5555_5555_8000, 0, 0);
        add_word(64'hF000_0000_0000_0000, 0, 0);   // unknown, must not touch state
        add_word(64'hBAAA_AAAA_AAAA_8000, 0, 0);
        add_word(64'h5AAA_AAAA_AAAA_AAAA, 0, 0);
        add_word(64'h5555_5555_5555_5555, 0, 0);
        for (int t = 0; t < 16; t++) begin
            p = {$urandom, $urandom};
            p[63:60] = 4'(t);
            add_word(p, 0, 0);
        end

        coarse = '0;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            ph = sent * 4 / RANDOM_WORDS;
            r = $urandom_range(99);
            if (r < 50) begin
                coarse = next_coarse(coarse);
                p = pixel_word(coarse);
            end else if (r < 85) begin
                coarse = next_coarse(coarse);
                p = trigger_word(coarse);
            end else if (r < 97) begin
                p = other_word();
            end else begin
                p = '0;
            end
            add_word(p, idle_tab[ph], stall_tab[ph]);
            sent++;
        end

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        wait (words_in == words_queued);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words in, %0d results: %0d pixel, %0d trigger, %0d wraps",
                 words_in, results_out, pixel_seen, trigger_seen, wraps_seen);
        $display("phases: no idle, sender idle, receiver stall, both; one long receiver hold");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // input driver
    always @(negedge aclk) begin : driver
        feed_t nxt;
        if (aresetn && (!s_valid || word_taken)) begin
            if (packet_fifo.size() != 0 &&
                $urandom_range(99) >= packet_fifo[0].send_idle) begin
                nxt = packet_fifo.pop_front();
                offered = nxt;
                s_valid <= 1'b1;
                s_packet <= nxt.packet;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold to back up the pipeline
    always @(negedge aclk) begin : receiver
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && words_in >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin : monitor
        decoded_t got;
        decoded_t want;
        string    diff;
        word_taken = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_col_x, m_row_y, m_fine_toa, m_over_threshold, m_arrival,
                       m_stamp, m_internal_trigger, m_external_trigger, m_unfolded};
                results_out++;
                if (pending_results.size() == 0) begin
                    report($sformatf("unexpected result: %s", show(got)));
                end else begin
                    want = pending_results.pop_front();
                    diff = field_diff(got, want);
                    if (diff != "") begin
                        report($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                                         results_out, diff, show(want), show(got)));
                    end
                end
            end
            if (s_valid && s_ready) begin
                word_taken = 1;
                words_in++;
                stall_pct = offered.recv_stall;
                if (decode_word(s_packet, want)) begin
                    pending_results.insert(pending_results.size(), want);
                    if (want.kind == KIND_PIXEL) pixel_seen++;
                    else trigger_seen++;
                    if (want.unfolded) wraps_seen++;
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: %0d words in, %0d results pending",
                         words_in, pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule
